// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hypotenuse block assertion failed");

// assertion on the block clock and reset
`define ASSERT_STD(lbl, prop) `ASSERT_AT(lbl, i_clk, i_rst_n, prop)

`endif

// ----- hdl/hypsq_pkg.sv -----
// constants, widths and state type for the hypotenuse approximation block
package hypsq_pkg;

    localparam int LEG_WIDTH = 16;
    localparam int FRAC_BITS = 16;

    // output field width
    localparam int HYP_W = 33;

    // root width, square sum width, newton numerator width
    localparam int R_W   = LEG_WIDTH + 1;
    localparam int N_W   = 2 * LEG_WIDTH + 1;
    localparam int M_W   = 2 * R_W + 1;
    // square root shift source, quotient, shared subtractor
    localparam int SQ_W  = 2 * R_W;
    localparam int Q_W   = R_W + FRAC_BITS;
    localparam int SUB_W = R_W + 3;
    localparam int CNT_W = $clog2(Q_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQA,
        S_SQB,
        S_ROOT,
        S_PICK,
        S_JSQ,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ----- hdl/hypotenuse_approx_sqrt.sv -----
// hypotenuse approximation: squares, bitwise square root, one newton step
// sequence from an accepted item to o_valid: multiply states S_SQA and S_SQB,
//   bitwise root steps, setup states S_PICK and S_JSQ, division steps on the shared subtractor
// zero leg: result shows in the cycle after the item is accepted
// one item at a time: a new item is taken only after the result has been accepted
// reset: synchronous active-low i_rst_n returns the sequencer to idle
module hypotenuse_approx_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hypsq_pkg::LEG_WIDTH-1:0]     i_leg_a,
    input  logic [hypsq_pkg::LEG_WIDTH-1:0]     i_leg_b,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hypsq_pkg::HYP_W-1:0]         o_hypotenuse,
    output logic                                o_leg_error
);

    hypsq_pkg::t_state r_state, n_state;
    logic [hypsq_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    logic [hypsq_pkg::LEG_WIDTH-1:0] r_a, r_b, n_a, n_b;
    logic                            r_err, n_err;
    logic [hypsq_pkg::N_W-1:0]       r_n, n_n;
    logic [hypsq_pkg::SQ_W-1:0]      r_sq, n_sq;
    logic [hypsq_pkg::SUB_W-1:0]     r_rem, n_rem;
    logic [hypsq_pkg::R_W-1:0]       r_root, n_root;
    logic [hypsq_pkg::R_W-1:0]       r_j, n_j;
    logic [hypsq_pkg::Q_W-1:0]       r_num, n_num;

    logic                            w_accept;
    logic                            w_zero_leg;
    logic [hypsq_pkg::R_W-1:0]       w_mul;
    logic [2*hypsq_pkg::R_W-1:0]     w_prod;
    logic [hypsq_pkg::M_W-1:0]       w_m;
    logic [hypsq_pkg::SUB_W-1:0]     w_opa, w_opb;
    logic [hypsq_pkg::SUB_W:0]       w_diff;
    logic                            w_ge;

    assign w_accept   = i_valid && (r_state == hypsq_pkg::S_IDLE);
    assign w_zero_leg = (i_leg_a == '0) || (i_leg_b == '0);

    // shared multiplier: a*a, b*b, then j*j
    always_comb begin
        unique case (r_state)
            hypsq_pkg::S_SQA: w_mul = hypsq_pkg::R_W'(r_a);
            hypsq_pkg::S_SQB: w_mul = hypsq_pkg::R_W'(r_b);
            default:          w_mul = r_j;
        endcase
    end

    assign w_prod = {{hypsq_pkg::R_W{1'b0}}, w_mul} * {{hypsq_pkg::R_W{1'b0}}, w_mul};
    assign w_m    = hypsq_pkg::M_W'(r_n) + hypsq_pkg::M_W'(w_prod);

    // shared compare and subtract unit
    always_comb begin
        unique case (r_state)
            hypsq_pkg::S_ROOT: begin
                w_opa = {r_rem[hypsq_pkg::SUB_W-3:0], r_sq[hypsq_pkg::SQ_W-1 -: 2]};
                w_opb = hypsq_pkg::SUB_W'({r_root, 2'b01});
            end
            hypsq_pkg::S_PICK: begin
                // root - rem borrows when rem > root: nearest root is root + 1
                w_opa = hypsq_pkg::SUB_W'(r_root);
                w_opb = r_rem;
            end
            default: begin
                w_opa = {r_rem[hypsq_pkg::SUB_W-2:0], r_num[hypsq_pkg::Q_W-1]};
                w_opb = hypsq_pkg::SUB_W'({r_j, 1'b0});
            end
        endcase
    end

    assign w_diff = {1'b0, w_opa} - {1'b0, w_opb};
    assign w_ge   = !w_diff[hypsq_pkg::SUB_W];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hypsq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = w_zero_leg ? hypsq_pkg::S_OUT : hypsq_pkg::S_SQA;
                end
            end
            hypsq_pkg::S_SQA:  n_state = hypsq_pkg::S_SQB;
            hypsq_pkg::S_SQB:  n_state = hypsq_pkg::S_ROOT;
            hypsq_pkg::S_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = hypsq_pkg::S_PICK;
                end
            end
            hypsq_pkg::S_PICK: n_state = hypsq_pkg::S_JSQ;
            hypsq_pkg::S_JSQ:  n_state = hypsq_pkg::S_DIV;
            hypsq_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = hypsq_pkg::S_OUT;
                end
            end
            hypsq_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_state = hypsq_pkg::S_IDLE;
                end
            end
            default: n_state = hypsq_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_stall = (r_state != hypsq_pkg::S_IDLE);
        o_valid = (r_state == hypsq_pkg::S_OUT);
    end

    // datapath next values
    always_comb begin
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_err  = r_err;
        n_n    = r_n;
        n_sq   = r_sq;
        n_rem  = r_rem;
        n_root = r_root;
        n_j    = r_j;
        n_num  = r_num;
        unique case (r_state)
            hypsq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_a   = i_leg_a;
                    n_b   = i_leg_b;
                    n_err = w_zero_leg;
                    n_num = '0;
                end
            end
            hypsq_pkg::S_SQA: begin
                n_n = hypsq_pkg::N_W'(w_prod);
            end
            hypsq_pkg::S_SQB: begin
                n_n    = r_n + hypsq_pkg::N_W'(w_prod);
                n_sq   = hypsq_pkg::SQ_W'(r_n + hypsq_pkg::N_W'(w_prod));
                n_rem  = '0;
                n_root = '0;
                n_cnt  = hypsq_pkg::CNT_W'(hypsq_pkg::R_W - 1);
            end
            hypsq_pkg::S_ROOT: begin
                n_sq  = {r_sq[hypsq_pkg::SQ_W-3:0], 2'b00};
                n_cnt = r_cnt - 1'b1;
                if (w_ge) begin
                    n_rem  = w_diff[hypsq_pkg::SUB_W-1:0];
                    n_root = {r_root[hypsq_pkg::R_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_opa;
                    n_root = {r_root[hypsq_pkg::R_W-2:0], 1'b0};
                end
            end
            hypsq_pkg::S_PICK: begin
                n_j = w_ge ? r_root : r_root + 1'b1;
            end
            hypsq_pkg::S_JSQ: begin
                // high part of n + j*j is below 2j, low part and fraction shift in
                n_rem = hypsq_pkg::SUB_W'(w_m[hypsq_pkg::M_W-1:hypsq_pkg::R_W]);
                n_num = hypsq_pkg::Q_W'(w_m[hypsq_pkg::R_W-1:0]) << hypsq_pkg::FRAC_BITS;
                n_cnt = hypsq_pkg::CNT_W'(hypsq_pkg::Q_W - 1);
            end
            hypsq_pkg::S_DIV: begin
                n_cnt = r_cnt - 1'b1;
                n_num = {r_num[hypsq_pkg::Q_W-2:0], w_ge};
                n_rem = w_ge ? w_diff[hypsq_pkg::SUB_W-1:0] : w_opa;
            end
            hypsq_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hypsq_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_err  <= n_err;
        r_n    <= n_n;
        r_sq   <= n_sq;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_j    <= n_j;
        r_num  <= n_num;
    end

    assign o_hypotenuse = hypsq_pkg::HYP_W'(r_num);
    assign o_leg_error  = r_err;

endmodule

// ----- hdl/hypsq_chk.sv -----
// port-level checker for the hypotenuse approximation block, with its bind
`include "assert_macros.svh"

module hypsq_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [hypsq_pkg::LEG_WIDTH-1:0] i_leg_a,
    input logic [hypsq_pkg::LEG_WIDTH-1:0] i_leg_b,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [hypsq_pkg::HYP_W-1:0]     o_hypotenuse,
    input logic                            o_leg_error
);

    logic w_in_acc;
    logic w_out_acc;
    logic w_zero_in;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    assign w_zero_in = (i_leg_a == '0) || (i_leg_b == '0);

    // block goes busy once it takes an item
    `ASSERT_STD(a_busy_after_accept, w_in_acc |=> o_stall)
    // no new item while a result waits
    `ASSERT_STD(a_stall_while_valid, o_valid |-> o_stall)
    // zero leg gives an error result straight away
    `ASSERT_STD(a_zero_leg_fast, w_in_acc && w_zero_in |=> o_valid && o_leg_error)
    // an error result carries zero
    `ASSERT_STD(a_error_zero, o_valid && o_leg_error |-> o_hypotenuse == '0)
    // ready again right after the result is taken
    `ASSERT_STD(a_ready_after_out, w_out_acc |=> !o_stall)

endmodule

bind hypotenuse_approx_sqrt hypsq_chk u_hypsq_chk (.*);
